/* rtl/core/uart_baud_divisor_from_clock_tree_unit_assert.svh */
// ----------------------------------------------------------------------------
// UART baud divisor assertion macros
// Small wrappers for the concurrent checks in the top level, on clk / rst_n.
// ----------------------------------------------------------------------------
`ifndef UART_BAUD_DIVISOR_FROM_CLOCK_TREE_UNIT_ASSERT_SVH
`define UART_BAUD_DIVISOR_FROM_CLOCK_TREE_UNIT_ASSERT_SVH

// antecedent holds in a cycle, consequent in the same cycle
`define UBD_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ubd: same-cycle check failed");

// antecedent holds in a cycle, consequent in the next one
`define UBD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ubd: next-cycle check failed");

`endif

/* rtl/core/ubd_pkg.sv */
// ----------------------------------------------------------------------------
// ubd_pkg
// Types, constants and prescaler tables shared by the baud divisor unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ubd_pkg;

  // oscillator frequencies
  localparam int unsigned HSI_HZ = 16000000;
  localparam int unsigned HSE_HZ = 25000000;

  // field widths
  localparam int DIV_W    = 32;  // baud division width
  localparam int WORD_W   = 16;
  localparam int STAT_W   = 2;
  localparam int MANT_W   = 12;
  localparam int CFG_W    = 9;   // widest register
  localparam int CFG_IX_W = 3;

  // baud divider pipeline
  localparam int STEPS_PER_STAGE = 4;
  localparam int DIV_STAGES      = DIV_W / STEPS_PER_STAGE;

  // clock tree divider: source / (M * P)
  localparam int SRC_W  = 26;    // holds any oscillator frequency
  localparam int DSR_W  = 9;     // M * P up to 504
  localparam int CNT_W  = $clog2(SRC_W);
  localparam int PROD_W = SRC_W + 9;

  // register reset values
  localparam logic [5:0] PLL_M_RST = 6'd16;
  localparam logic [8:0] PLL_N_RST = 9'd192;

  localparam logic [WORD_W-1:0] WORD_SAT = '1;

  typedef logic [STAT_W-1:0] status_t;
  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_ZERO_BAUD = 2'd1;
  localparam status_t ST_SATURATED = 2'd2;

  typedef enum logic [CFG_IX_W-1:0] {
    CFG_SYSCLK_SOURCE,
    CFG_AHB_PRESCALE,
    CFG_APB1_PRESCALE,
    CFG_APB2_PRESCALE,
    CFG_PLL_INPUT_SEL,
    CFG_PLL_M,
    CFG_PLL_N,
    CFG_PLL_P_CODE
  } cfg_index_t;

  typedef enum logic [1:0] {
    SYS_HSI     = 2'd0,
    SYS_HSE     = 2'd1,
    SYS_PLL     = 2'd2,
    SYS_HSI_ALT = 2'd3
  } sys_src_t;

  typedef enum logic [2:0] {
    CK_LOAD,
    CK_DIV,
    CK_MUL,
    CK_OUT,
    CK_IDLE
  } ck_state_t;

  // bus clocks handed from the clock tree to the datapath
  typedef struct packed {
    logic             ready;
    logic [DIV_W-1:0] pclk1;
    logic [DIV_W-1:0] pclk2;
  } ubd_clk_info_t;

  // one item in flight through the divider
  typedef struct packed {
    logic [DIV_W-1:0] bus_clock;
    logic [DIV_W-1:0] baud;
    logic             eight;
    logic [DIV_W-1:0] rem;
    logic [DIV_W-1:0] qd;    // dividend bits out, quotient bits in
  } ubd_item_t;

  // ahb divide 1,..,1,2,4,8,16,64,128,256,512 as a right shift
  function automatic logic [3:0] ahb_shift(input logic [3:0] code);
    logic [3:0] sh;
    unique case (code)
      4'd8:    sh = 4'd1;
      4'd9:    sh = 4'd2;
      4'd10:   sh = 4'd3;
      4'd11:   sh = 4'd4;
      4'd12:   sh = 4'd6;
      4'd13:   sh = 4'd7;
      4'd14:   sh = 4'd8;
      4'd15:   sh = 4'd9;
      default: sh = 4'd0;
    endcase
    return sh;
  endfunction

  // apb divide 1,1,1,1,2,4,8,16 as a right shift
  function automatic logic [2:0] apb_shift(input logic [2:0] code);
    logic [2:0] sh;
    unique case (code)
      3'd4:    sh = 3'd1;
      3'd5:    sh = 3'd2;
      3'd6:    sh = 3'd3;
      3'd7:    sh = 3'd4;
      default: sh = 3'd0;
    endcase
    return sh;
  endfunction

endpackage

/* rtl/core/ubd_clk_tree.sv */
// ----------------------------------------------------------------------------
// ubd_clk_tree
// Clock tree registers and a small sequencer that derives both bus clocks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ubd_clk_tree (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [ubd_pkg::CFG_IX_W-1:0]  cfg_index,
  input  logic [ubd_pkg::CFG_W-1:0]     cfg_wr_data,
  output ubd_pkg::ubd_clk_info_t        info
);
  import ubd_pkg::*;

  logic [1:0]       sys_src_r;
  logic [3:0]       ahb_code_r;
  logic [2:0]       apb1_code_r;
  logic [2:0]       apb2_code_r;
  logic             pll_sel_r;
  logic [5:0]       pll_m_r;
  logic [8:0]       pll_n_r;
  logic [1:0]       pll_p_code_r;

  ck_state_t        state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [DSR_W-1:0] dsr_r;
  logic [DSR_W-1:0] rem_r;
  logic [SRC_W-1:0] qd_r;
  logic [DIV_W-1:0] pll_r;
  logic [DIV_W-1:0] pclk1_r;
  logic [DIV_W-1:0] pclk2_r;

  logic [5:0]        m_eff;
  logic [3:0]        p_val;
  logic [SRC_W-1:0]  src_hz;
  logic [DSR_W:0]    trial;
  logic              ge;
  logic [PROD_W-1:0] prod;
  logic [DIV_W-1:0]  sys_hz;
  logic [DIV_W-1:0]  hclk;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sys_src_r    <= '0;
      ahb_code_r   <= '0;
      apb1_code_r  <= '0;
      apb2_code_r  <= '0;
      pll_sel_r    <= 1'b0;
      pll_m_r      <= PLL_M_RST;
      pll_n_r      <= PLL_N_RST;
      pll_p_code_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_SYSCLK_SOURCE: sys_src_r    <= cfg_wr_data[1:0];
        CFG_AHB_PRESCALE:  ahb_code_r   <= cfg_wr_data[3:0];
        CFG_APB1_PRESCALE: apb1_code_r  <= cfg_wr_data[2:0];
        CFG_APB2_PRESCALE: apb2_code_r  <= cfg_wr_data[2:0];
        CFG_PLL_INPUT_SEL: pll_sel_r    <= cfg_wr_data[0];
        CFG_PLL_M:         pll_m_r      <= cfg_wr_data[5:0];
        CFG_PLL_N:         pll_n_r      <= cfg_wr_data[8:0];
        CFG_PLL_P_CODE:    pll_p_code_r <= cfg_wr_data[1:0];
        default: ;
      endcase
    end
  end

  // (src / M) / P truncates the same as src / (M * P)
  assign m_eff  = (pll_m_r == 6'd0) ? 6'd1 : pll_m_r;
  assign p_val  = {1'b0, pll_p_code_r, 1'b0} + 4'd2;
  assign src_hz = pll_sel_r ? SRC_W'(HSE_HZ) : SRC_W'(HSI_HZ);

  assign trial = {rem_r, qd_r[SRC_W-1]};
  assign ge    = (trial >= {1'b0, dsr_r});
  assign prod  = PROD_W'(qd_r) * PROD_W'(pll_n_r);

  always_comb begin
    unique case (sys_src_t'(sys_src_r))
      SYS_HSE:     sys_hz = DIV_W'(HSE_HZ);
      SYS_PLL:     sys_hz = pll_r;
      SYS_HSI,
      SYS_HSI_ALT: sys_hz = DIV_W'(HSI_HZ);
    endcase
  end

  assign hclk = sys_hz >> ahb_shift(ahb_code_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      CK_LOAD: state_nxt = CK_DIV;
      CK_DIV:  if (cnt_r == CNT_W'(SRC_W - 1)) state_nxt = CK_MUL;
      CK_MUL:  state_nxt = CK_OUT;
      CK_OUT:  state_nxt = CK_IDLE;
      CK_IDLE: state_nxt = CK_IDLE;
    endcase
    // any register write restarts the derivation
    if (cfg_wr_en) state_nxt = CK_LOAD;
  end

  // outputs
  always_comb begin
    info.ready = (state_r == CK_IDLE);
    info.pclk1 = pclk1_r;
    info.pclk2 = pclk2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CK_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      CK_LOAD: begin
        cnt_r <= '0;
        dsr_r <= DSR_W'(m_eff) * DSR_W'(p_val);
        rem_r <= '0;
        qd_r  <= src_hz;
      end
      CK_DIV: begin
        cnt_r <= cnt_r + CNT_W'(1);
        rem_r <= ge ? DSR_W'(trial - {1'b0, dsr_r}) : trial[DSR_W-1:0];
        qd_r  <= {qd_r[SRC_W-2:0], ge};
      end
      CK_MUL: begin
        pll_r <= (|prod[PROD_W-1:DIV_W]) ? '1 : prod[DIV_W-1:0];
      end
      CK_OUT: begin
        pclk1_r <= hclk >> apb_shift(apb1_code_r);
        pclk2_r <= hclk >> apb_shift(apb2_code_r);
      end
      CK_IDLE: ;
    endcase
  end

endmodule

/* rtl/core/ubd_div_stage.sv */
// ----------------------------------------------------------------------------
// ubd_div_stage
// One pipeline stage of the restoring baud divider, STEPS_PER_STAGE (four) quotient bits each.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ubd_div_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ubd_pkg::ubd_item_t in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output ubd_pkg::ubd_item_t out_item
);
  import ubd_pkg::*;

  logic      valid_r, valid_nxt;
  ubd_item_t item_r;
  ubd_item_t item_c;
  logic [DIV_W:0] trial;
  logic           ge;

  always_comb begin
    item_c = in_item;
    trial  = '0;
    ge     = 1'b0;
    for (int k = 0; k < STEPS_PER_STAGE; k++) begin
      trial       = {item_c.rem, item_c.qd[DIV_W-1]};
      ge          = (trial >= {1'b0, item_c.baud});
      item_c.qd   = {item_c.qd[DIV_W-2:0], ge};
      item_c.rem  = ge ? DIV_W'(trial - {1'b0, item_c.baud}) : trial[DIV_W-1:0];
    end
  end

  assign in_ready  = !valid_r || out_ready;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= item_c;
    end
  end

  assign out_valid = valid_r;
  assign out_item  = item_r;

endmodule

/* rtl/core/ubd_round_fmt.sv */
// ----------------------------------------------------------------------------
// ubd_round_fmt
// Rounds the quotient half up and packs the divisor word; output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ubd_round_fmt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  ubd_pkg::ubd_item_t         in_item,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [ubd_pkg::WORD_W-1:0] out_divisor_word,
  output ubd_pkg::status_t           out_status,
  output logic [ubd_pkg::DIV_W-1:0]  out_bus_clock_hz
);
  import ubd_pkg::*;

  logic                valid_r, valid_nxt;
  logic [WORD_W-1:0]   word_r, word_c;
  status_t             status_r, status_c;
  logic [DIV_W-1:0]    bus_clock_r;
  logic                round_up;
  logic [DIV_W:0]      r_val;
  logic                ovf;

  // remainder at least half the baud rate rounds up
  assign round_up = ({in_item.rem, 1'b0} >= {1'b0, in_item.baud});
  assign r_val    = {1'b0, in_item.qd} + (DIV_W + 1)'(round_up);
  assign ovf      = in_item.eight ? (|r_val[DIV_W:MANT_W+3]) : (|r_val[DIV_W:MANT_W+4]);

  always_comb begin
    priority if (in_item.baud == '0) begin
      word_c   = '0;
      status_c = ST_ZERO_BAUD;
    end else if (ovf) begin
      word_c   = WORD_SAT;
      status_c = ST_SATURATED;
    end else if (in_item.eight) begin
      word_c   = {r_val[MANT_W+2:3], r_val[2:0], 1'b0};
      status_c = ST_OK;
    end else begin
      word_c   = r_val[WORD_W-1:0];
      status_c = ST_OK;
    end
  end

  assign in_ready  = !valid_r || out_ready;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      word_r      <= word_c;
      status_r    <= status_c;
      bus_clock_r <= in_item.bus_clock;
    end
  end

  assign out_valid        = valid_r;
  assign out_divisor_word = word_r;
  assign out_status       = status_r;
  assign out_bus_clock_hz = bus_clock_r;

endmodule

/* rtl/core/uart_baud_divisor_from_clock_tree_unit.sv */
// ----------------------------------------------------------------------------
// uart_baud_divisor_from_clock_tree_unit
// Derives the UART baud divisor word from the clock tree settings.
//
//   channel   direction  handshake              payload
//   in_       sink       in_valid / in_ready    bus_select, oversample_eight,
//                                               baud_rate
//   out_      source     out_valid / out_ready  divisor_word, status,
//                                               bus_clock_hz
//   cfg_      sink       cfg_wr_en              cfg_index, cfg_wr_data
//
// one transfer per cycle while out_ready and the clock tree are ready;
// items pass 8 divider stages of 4 quotient bits, then rounding and packing
// after reset and after every register write the clock tree sequencer
// derives the bus clocks: load, bit-serial M*P divider, multiply, output;
// in_ready stays low until it is done
// back-pressure ripples stage by stage, so bubbles are squeezed out
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "uart_baud_divisor_from_clock_tree_unit_assert.svh"

module uart_baud_divisor_from_clock_tree_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_bus_select,
  input  logic                         in_oversample_eight,
  input  logic [ubd_pkg::DIV_W-1:0]    in_baud_rate,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [ubd_pkg::WORD_W-1:0]   out_divisor_word,
  output logic [ubd_pkg::STAT_W-1:0]   out_status,
  output logic [ubd_pkg::DIV_W-1:0]    out_bus_clock_hz,
  input  logic                         cfg_wr_en,
  input  logic [ubd_pkg::CFG_IX_W-1:0] cfg_index,
  input  logic [ubd_pkg::CFG_W-1:0]    cfg_wr_data
);
  import ubd_pkg::*;

  ubd_clk_info_t ck_info;
  logic          s_valid [DIV_STAGES+1];
  logic          s_ready [DIV_STAGES+1];
  ubd_item_t     s_item  [DIV_STAGES+1];

  ubd_clk_tree u_clk_tree (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data),
    .info        (ck_info)
  );

  // entry: pick the bus clock, load it as the dividend
  always_comb begin
    s_item[0].bus_clock = in_bus_select ? ck_info.pclk2 : ck_info.pclk1;
    s_item[0].baud      = in_baud_rate;
    s_item[0].eight     = in_oversample_eight;
    s_item[0].rem       = '0;
    s_item[0].qd        = in_bus_select ? ck_info.pclk2 : ck_info.pclk1;
  end

  assign s_valid[0] = in_valid && ck_info.ready;
  assign in_ready   = s_ready[0] && ck_info.ready;

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    ubd_div_stage u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (s_valid[g]),
      .in_ready  (s_ready[g]),
      .in_item   (s_item[g]),
      .out_valid (s_valid[g+1]),
      .out_ready (s_ready[g+1]),
      .out_item  (s_item[g+1])
    );
  end

  ubd_round_fmt u_round_fmt (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (s_valid[DIV_STAGES]),
    .in_ready         (s_ready[DIV_STAGES]),
    .in_item          (s_item[DIV_STAGES]),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_divisor_word (out_divisor_word),
    .out_status       (out_status),
    .out_bus_clock_hz (out_bus_clock_hz)
  );

  // a register write holds off new transfers while the bus clocks settle
  `UBD_ASSERT_NEXT(a_cfg_blocks_input, cfg_wr_en, !in_ready)
  // zero baud rate always comes out with an all-zero word
  `UBD_ASSERT_SAME(a_zero_word, out_valid && out_status == ST_ZERO_BAUD, out_divisor_word == '0)
  // a saturated result carries the saturated word
  `UBD_ASSERT_SAME(a_sat_word, out_valid && out_status == ST_SATURATED, out_divisor_word == WORD_SAT)

endmodule

/* tb/tb_uart_baud_divisor_from_clock_tree_unit.sv */
// ----------------------------------------------------------------------------
// tb_uart_baud_divisor_from_clock_tree_unit
// Drives baud requests through the divisor unit under a range of clock tree
// settings. Every result is checked field by field against a typed value or a
// local model of the PLL, the bus prescalers and the rounded divisor packing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_uart_baud_divisor_from_clock_tree_unit;
  import ubd_pkg::*;

  localparam int DIR_N          = 22;
  localparam int FIXED_PHASES   = 4;
  localparam int N_PHASES       = 8;
  localparam int REQS_PER_PHASE = 155;
  localparam int DRAIN_CYCLES   = 12;
  localparam int STALL_CYCLES   = 300;
  localparam int QUIET_LIMIT    = 3000;

  typedef struct packed {
    logic [1:0] sys_src;
    logic [3:0] ahb_code;
    logic [2:0] apb1_code;
    logic [2:0] apb2_code;
    logic       pll_sel;
    logic [5:0] pll_m;
    logic [8:0] pll_n;
    logic [1:0] pll_p_code;
  } clk_tree_t;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    status_t           status;
    logic [DIV_W-1:0]  bus_clk;
  } baud_res_t;

  typedef struct packed {
    logic             apb2;
    logic             eight;
    logic [DIV_W-1:0] baud;
    logic             typed;
    baud_res_t        res;
  } dir_row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                in_bus_select = 1'b0;
  logic                in_oversample_eight = 1'b0;
  logic [DIV_W-1:0]    in_baud_rate = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [WORD_W-1:0]   out_divisor_word;
  logic [STAT_W-1:0]   out_status;
  logic [DIV_W-1:0]    out_bus_clock_hz;
  logic                cfg_wr_en = 1'b0;
  logic [CFG_IX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]    cfg_wr_data = '0;

  clk_tree_t   tree;
  baud_res_t   owed_results [$];
  int unsigned err_cnt = 0;
  int unsigned quiet_cnt = 0;
  int unsigned stall_left = 0;
  logic        idle_on = 1'b1;
  logic        stall_req = 1'b0;
  logic        stall_done = 1'b0;

  // directed requests under reset settings: HSI straight through, 16 MHz on both buses
  dir_row_t dir_rows [DIR_N] = '{
    '{1'b0, 1'b0, 32'd0,          1'b1, '{16'h0000, ST_ZERO_BAUD, 32'd16000000}},
    '{1'b1, 1'b1, 32'd0,          1'b1, '{16'h0000, ST_ZERO_BAUD, 32'd16000000}},
    '{1'b0, 1'b0, 32'd1,          1'b1, '{16'hFFFF, ST_SATURATED, 32'd16000000}},
    '{1'b1, 1'b1, 32'd1,          1'b1, '{16'hFFFF, ST_SATURATED, 32'd16000000}},
    '{1'b0, 1'b0, 32'hFFFF_FFFF,  1'b1, '{16'h0000, ST_OK,        32'd16000000}},
    '{1'b1, 1'b1, 32'hFFFF_FFFF,  1'b1, '{16'h0000, ST_OK,        32'd16000000}},
    '{1'b0, 1'b0, 32'd115200,     1'b1, '{16'h008B, ST_OK,        32'd16000000}},
    '{1'b0, 1'b1, 32'd115200,     1'b1, '{16'h0116, ST_OK,        32'd16000000}},
    '{1'b1, 1'b0, 32'd9600,       1'b1, '{16'h0683, ST_OK,        32'd16000000}},
    // exact half rounds up
    '{1'b1, 1'b0, 32'd6400000,    1'b1, '{16'h0003, ST_OK,        32'd16000000}},
    '{1'b1, 1'b1, 32'd6400000,    1'b1, '{16'h0006, ST_OK,        32'd16000000}},
    '{1'b1, 1'b0, 32'd32000000,   1'b1, '{16'h0001, ST_OK,        32'd16000000}},
    '{1'b0, 1'b0, 32'd32000001,   1'b1, '{16'h0000, ST_OK,        32'd16000000}},
    // either side of the mantissa limit
    '{1'b0, 1'b0, 32'd244,        1'b0, '0},
    '{1'b0, 1'b0, 32'd245,        1'b0, '0},
    '{1'b1, 1'b1, 32'd488,        1'b0, '0},
    '{1'b1, 1'b1, 32'd489,        1'b0, '0},
    '{1'b0, 1'b1, 32'h8000_0000,  1'b0, '0},
    '{1'b1, 1'b0, 32'h5555_5555,  1'b0, '0},
    '{1'b0, 1'b1, 32'hAAAA_AAAA,  1'b0, '0},
    '{1'b1, 1'b0, 32'h0000_FFFF,  1'b0, '0},
    '{1'b0, 1'b1, 32'd1000000,    1'b0, '0}
  };

  // register order: source, ahb, apb1, apb2, pll input, M, N, P code
  logic [CFG_W-1:0] phase_cfg [FIXED_PHASES][8] = '{
    '{9'd2, 9'd0,  9'd0, 9'd7, 9'd1, 9'd0,  9'd511, 9'd0},  // pll saturates, M of zero
    '{9'd2, 9'd15, 9'd7, 9'd4, 9'd0, 9'd63, 9'd0,   9'd3},  // pll at zero hertz
    '{9'd1, 9'd8,  9'd5, 9'd6, 9'd1, 9'd2,  9'd432, 9'd1},
    '{9'd3, 9'd11, 9'd3, 9'd5, 9'd0, 9'd1,  9'd50,  9'd2}
  };

  uart_baud_divisor_from_clock_tree_unit u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_bus_select       (in_bus_select),
    .in_oversample_eight (in_oversample_eight),
    .in_baud_rate        (in_baud_rate),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_divisor_word    (out_divisor_word),
    .out_status          (out_status),
    .out_bus_clock_hz    (out_bus_clock_hz),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_index           (cfg_index),
    .cfg_wr_data         (cfg_wr_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic baud_res_t calc_baud_word(input clk_tree_t t, input logic apb2,
                                               input logic eight, input logic [DIV_W-1:0] baud);
    logic [63:0] src;
    logic [63:0] m;
    logic [63:0] p;
    logic [63:0] sys_hz;
    logic [63:0] ahb_div;
    logic [63:0] apb_div;
    logic [63:0] pclk;
    logic [63:0] r;
    logic [63:0] mant;
    logic [2:0]  apb_code;
    baud_res_t   res;
    src = t.pll_sel ? 64'(HSE_HZ) : 64'(HSI_HZ);
    m = (t.pll_m == '0) ? 64'd1 : 64'(t.pll_m);
    p = (64'(t.pll_p_code) + 64'd1) * 64'd2;
    case (sys_src_t'(t.sys_src))
      SYS_HSE: sys_hz = 64'(HSE_HZ);
      SYS_PLL: begin
        // truncate after each divide, clamp the product to 32 bits
        sys_hz = (src / m) / p * 64'(t.pll_n);
        if (sys_hz > 64'hFFFF_FFFF) sys_hz = 64'hFFFF_FFFF;
      end
      default: sys_hz = 64'(HSI_HZ);
    endcase
    if (!t.ahb_code[3]) ahb_div = 64'd1;
    else if (!t.ahb_code[2]) ahb_div = 64'd2 << t.ahb_code[1:0];
    else ahb_div = 64'd64 << t.ahb_code[1:0];
    apb_code = apb2 ? t.apb2_code : t.apb1_code;
    apb_div = apb_code[2] ? (64'd2 << apb_code[1:0]) : 64'd1;
    pclk = (sys_hz / ahb_div) / apb_div;
    res.bus_clk = pclk[DIV_W-1:0];
    if (baud == '0) begin
      res.word = '0;
      res.status = ST_ZERO_BAUD;
    end else begin
      // round half up, exact in integers
      r = (64'd2 * pclk + 64'(baud)) / (64'd2 * 64'(baud));
      mant = eight ? (r >> 3) : (r >> 4);
      if (mant > 64'd4095) begin
        res.word = WORD_SAT;
        res.status = ST_SATURATED;
      end else begin
        res.word = eight ? {mant[11:0], r[2:0], 1'b0} : {mant[11:0], r[3:0]};
        res.status = ST_OK;
      end
    end
    return res;
  endfunction

  task automatic send_req(input logic apb2, input logic eight, input logic [DIV_W-1:0] baud,
                          input baud_res_t res);
    if (idle_on && $urandom_range(0, 99) < 28) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_bus_select <= apb2;
    in_oversample_eight <= eight;
    in_baud_rate <= baud;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    owed_results.push_back(res);
  endtask

  task automatic check_result();
    baud_res_t want;
    if (owed_results.size() == 0) begin
      err_cnt++;
      $display("%0t: result with nothing owed: word %h status %0d clock %0d", $time,
               out_divisor_word, out_status, out_bus_clock_hz);
    end else begin
      want = owed_results.pop_front();
      if (out_divisor_word !== want.word) begin
        err_cnt++;
        $display("%0t: divisor_word expected %h actual %h", $time, want.word,
                 out_divisor_word);
      end
      if (out_status !== want.status) begin
        err_cnt++;
        $display("%0t: status expected %0d actual %0d", $time, want.status, out_status);
      end
      if (out_bus_clock_hz !== want.bus_clk) begin
        err_cnt++;
        $display("%0t: bus_clock_hz expected %0d actual %0d", $time, want.bus_clk,
                 out_bus_clock_hz);
      end
    end
  endtask

  // result side: random back-pressure plus one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) check_result();
      if (stall_req && !stall_done) begin
        stall_done <= 1'b1;
        stall_left <= STALL_CYCLES;
        out_ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= !idle_on || ($urandom_range(0, 99) >= 28);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en) begin
        quiet_cnt <= 0;
      end else if (quiet_cnt >= QUIET_LIMIT) begin
        $display("FAILURE");
        $finish;
      end else begin
        quiet_cnt <= quiet_cnt + 1;
      end
    end
  end

  initial begin
    int unsigned      i;
    int unsigned      ph;
    int unsigned      k;
    logic             apb2;
    logic             eight;
    logic [DIV_W-1:0] baud;
    logic [CFG_W-1:0] val;
    baud_res_t        res;

    tree = '{sys_src: SYS_HSI, ahb_code: 4'd0, apb1_code: 3'd0, apb2_code: 3'd0,
             pll_sel: 1'b0, pll_m: PLL_M_RST, pll_n: PLL_N_RST, pll_p_code: 2'd0};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < DIR_N; i++) begin
      res = dir_rows[i].typed ? dir_rows[i].res
          : calc_baud_word(tree, dir_rows[i].apb2, dir_rows[i].eight, dir_rows[i].baud);
      send_req(dir_rows[i].apb2, dir_rows[i].eight, dir_rows[i].baud, res);
    end
    in_valid <= 1'b0;

    for (ph = 0; ph < N_PHASES; ph++) begin
      // settings change only with the pipe empty
      while (owed_results.size() != 0) @(posedge clk);
      repeat (DRAIN_CYCLES) @(posedge clk);
      for (k = 0; k < 8; k++) begin
        // random phases also set the unused upper data bits
        val = (ph < FIXED_PHASES) ? phase_cfg[ph][k] : CFG_W'($urandom_range(0, 511));
        cfg_wr_en <= 1'b1;
        cfg_index <= k[CFG_IX_W-1:0];
        cfg_wr_data <= val;
        @(posedge clk);
        case (cfg_index_t'(k))
          CFG_SYSCLK_SOURCE: tree.sys_src = val[1:0];
          CFG_AHB_PRESCALE:  tree.ahb_code = val[3:0];
          CFG_APB1_PRESCALE: tree.apb1_code = val[2:0];
          CFG_APB2_PRESCALE: tree.apb2_code = val[2:0];
          CFG_PLL_INPUT_SEL: tree.pll_sel = val[0];
          CFG_PLL_M:         tree.pll_m = val[5:0];
          CFG_PLL_N:         tree.pll_n = val[8:0];
          default:           tree.pll_p_code = val[1:0];
        endcase
      end
      cfg_wr_en <= 1'b0;
      idle_on <= (ph != 2);
      if (ph == 0) stall_req <= 1'b1;

      for (i = 0; i < REQS_PER_PHASE; i++) begin
        apb2 = 1'($urandom_range(0, 1));
        eight = 1'($urandom_range(0, 1));
        res = calc_baud_word(tree, apb2, eight, '0);
        case ($urandom_range(0, 9))
          0:       baud = '0;
          1, 2:    baud = $urandom;
          // lands the rounded ratio around the mantissa range
          3, 4, 5: baud = res.bus_clk / $urandom_range(1, 70000);
          default: baud = $urandom >> $urandom_range(8, 31);
        endcase
        send_req(apb2, eight, baud, calc_baud_word(tree, apb2, eight, baud));
      end
      in_valid <= 1'b0;
    end

    while (owed_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
